// ----- rtl/bsc_pkg.sv -----
// shared types and constants of the barometric compensation core
package bsc_pkg;

  // field widths
  localparam int RAW_W     = 24;
  localparam int CAL_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int TEN_W     = 16;
  localparam int PA_W      = 18;
  localparam int D_W       = 25;
  localparam int T_W       = 19;
  localparam int OS_W      = 40;

  // temperature thresholds in hundredths of a degree
  localparam logic signed [T_W-1:0] T_LOW  = 19'sd2000;
  localparam logic signed [T_W-1:0] T_VLOW = -19'sd1500;

  // reciprocal of ten, scaled by 2^23
  localparam logic [19:0] RECIP10 = 20'd838861;

  // pressure saturation limit
  localparam logic [PA_W-1:0] PA_MAX = 18'h3FFFF;

  // calibration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CAL_PSENS = 3'd0,
    CAL_POFF  = 3'd1,
    CAL_STC   = 3'd2,
    CAL_OTC   = 3'd3,
    CAL_TREF  = 3'd4,
    CAL_TCOEF = 3'd5
  } bsc_cal_idx_t;

  // one input item
  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } bsc_in_t;

  // one result item
  typedef struct packed {
    logic signed [TEN_W-1:0] temperature_tenths;
    logic [PA_W-1:0]         pressure_pascal;
    logic                    pressure_clamped;
  } bsc_out_t;

  // calibration words
  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coef;
    logic [CAL_W-1:0] offset_temp_coef;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_coef;
  } bsc_cal_t;

  // handoff from temperature section to pressure section
  typedef struct packed {
    logic                    valid;
    logic [RAW_W-1:0]        raw_p;
    logic signed [TEN_W-1:0] tenths;
    logic signed [OS_W-1:0]  off;
    logic signed [OS_W-1:0]  sens;
  } bsc_comp_t;

endpackage

// ----- rtl/bsc_cal_regs.sv -----
// calibration word register file
module bsc_cal_regs import bsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAL_W-1:0]     cfg_wdata,
  output bsc_cal_t             cal
);

  bsc_cal_t cal_r, cal_nxt;

  // decode the write, unknown indexes are dropped
  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      case (bsc_cal_idx_t'(cfg_index))
        CAL_PSENS: cal_nxt.pressure_sensitivity  = cfg_wdata;
        CAL_POFF:  cal_nxt.pressure_offset       = cfg_wdata;
        CAL_STC:   cal_nxt.sensitivity_temp_coef = cfg_wdata;
        CAL_OTC:   cal_nxt.offset_temp_coef      = cfg_wdata;
        CAL_TREF:  cal_nxt.reference_temperature = cfg_wdata;
        CAL_TCOEF: cal_nxt.temperature_coef      = cfg_wdata;
        default:   cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cal = cal_r;

endmodule

// ----- rtl/bsc_temp_comp.sv -----
// temperature, offset and sensitivity pipeline (six stages)
module bsc_temp_comp import bsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  bsc_in_t   in_data,
  input  bsc_cal_t  cal,
  output bsc_comp_t comp
);

  logic [5:0] v_r, v_nxt;

  // stage 1: temperature difference
  logic signed [D_W-1:0]  d1_r, d1_nxt;
  logic [RAW_W-1:0]       rp1_r;

  // stage 2: products with the difference
  logic signed [41:0]     pt2_r, pt2_nxt;
  logic signed [41:0]     po2_r, po2_nxt;
  logic signed [41:0]     ps2_r, ps2_nxt;
  logic signed [49:0]     dd2_r, dd2_nxt;
  logic [RAW_W-1:0]       rp2_r;

  // stage 3: first-order values
  logic signed [41:0]     pt_q, po_q, ps_q;
  logic signed [T_W-1:0]  t3_r, t3_nxt;
  logic signed [OS_W-1:0] off3_r, off3_nxt;
  logic signed [OS_W-1:0] sens3_r, sens3_nxt;
  logic [17:0]            t23_r, t23_nxt;
  logic [RAW_W-1:0]       rp3_r;

  // stage 4: squares and region flags
  logic signed [T_W-1:0]  dl, dh;
  logic signed [37:0]     sql_full, sqh_full;
  logic [35:0]            sql4_r, sql4_nxt;
  logic [35:0]            sqh4_r, sqh4_nxt;
  logic                   lo4_r, lo4_nxt;
  logic                   vlo4_r, vlo4_nxt;
  logic signed [19:0]     tt4_r, tt4_nxt;
  logic signed [OS_W-1:0] off4_r, sens4_r;
  logic [RAW_W-1:0]       rp4_r;

  // stage 5: correction terms and tenths product
  logic [37:0]            sql5x;
  logic [38:0]            sqh7x, sqh11x;
  logic [19:0]            tmag;
  logic [38:0]            off25_r, off25_nxt;
  logic [38:0]            sens25_r, sens25_nxt;
  logic [37:0]            tm5_r, tm5_nxt;
  logic                   tneg5_r, tneg5_nxt;
  logic signed [OS_W-1:0] off5_r, sens5_r;
  logic [RAW_W-1:0]       rp5_r;

  // stage 6: corrected values
  logic signed [OS_W-1:0]  off6_r, off6_nxt;
  logic signed [OS_W-1:0]  sens6_r, sens6_nxt;
  logic signed [TEN_W-1:0] ten6_r, ten6_nxt;
  logic [RAW_W-1:0]        rp6_r;

  assign v_nxt = {v_r[4:0], in_valid};

  // stage 1 logic
  always_comb begin
    d1_nxt = $signed({1'b0, in_data.raw_temperature})
           - $signed({1'b0, cal.reference_temperature, 8'h00});
  end

  // stage 2 logic
  always_comb begin
    pt2_nxt = d1_r * $signed({1'b0, cal.temperature_coef});
    po2_nxt = d1_r * $signed({1'b0, cal.offset_temp_coef});
    ps2_nxt = d1_r * $signed({1'b0, cal.sensitivity_temp_coef});
    dd2_nxt = d1_r * d1_r;
  end

  // stage 3 logic, divisions truncate toward zero
  always_comb begin
    pt_q = (pt2_r + (pt2_r[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
    po_q = (po2_r + (po2_r[41] ? 42'sd127 : 42'sd0)) >>> 7;
    ps_q = (ps2_r + (ps2_r[41] ? 42'sd255 : 42'sd0)) >>> 8;
    t3_nxt    = $signed(pt_q[T_W-1:0]) + T_LOW;
    off3_nxt  = $signed({8'h00, cal.pressure_offset, 16'h0000})
              + $signed(po_q[OS_W-1:0]);
    sens3_nxt = $signed({9'h000, cal.pressure_sensitivity, 15'h0000})
              + $signed(ps_q[OS_W-1:0]);
    t23_nxt   = dd2_r[48:31];
  end

  // stage 4 logic, squared difference term only in the low region
  always_comb begin
    dl       = t3_r - T_LOW;
    dh       = t3_r - T_VLOW;
    sql_full = dl * dl;
    sqh_full = dh * dh;
    sql4_nxt = sql_full[35:0];
    sqh4_nxt = sqh_full[35:0];
    lo4_nxt  = t3_r < T_LOW;
    vlo4_nxt = t3_r < T_VLOW;
    tt4_nxt  = $signed({t3_r[T_W-1], t3_r})
             - (lo4_nxt ? $signed({2'b00, t23_r}) : 20'sd0);
  end

  // stage 5 logic, constant factors as shift and add
  always_comb begin
    sql5x  = {sql4_r, 2'b00} + {2'b00, sql4_r};
    sqh7x  = {sqh4_r, 3'b000} - {3'b000, sqh4_r};
    sqh11x = {sqh4_r, 3'b000} + {2'b00, sqh4_r, 1'b0} + {3'b000, sqh4_r};
    off25_nxt  = (lo4_r  ? {2'b00, sql5x[37:1]} : 39'd0)
               + (vlo4_r ? sqh7x : 39'd0);
    sens25_nxt = (lo4_r  ? {3'b000, sql5x[37:2]} : 39'd0)
               + (vlo4_r ? {1'b0, sqh11x[38:1]} : 39'd0);
    tmag      = tt4_r[19] ? 20'(-tt4_r) : 20'(tt4_r);
    tm5_nxt   = tmag[17:0] * RECIP10;
    tneg5_nxt = tt4_r[19];
  end

  // stage 6 logic
  always_comb begin
    off6_nxt  = off5_r - $signed({1'b0, off25_r});
    sens6_nxt = sens5_r - $signed({1'b0, sens25_r});
    ten6_nxt  = tneg5_r ? -$signed({1'b0, tm5_r[37:23]})
                        : $signed({1'b0, tm5_r[37:23]});
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      d1_r     <= d1_nxt;
      rp1_r    <= in_data.raw_pressure;
      pt2_r    <= pt2_nxt;
      po2_r    <= po2_nxt;
      ps2_r    <= ps2_nxt;
      dd2_r    <= dd2_nxt;
      rp2_r    <= rp1_r;
      t3_r     <= t3_nxt;
      off3_r   <= off3_nxt;
      sens3_r  <= sens3_nxt;
      t23_r    <= t23_nxt;
      rp3_r    <= rp2_r;
      sql4_r   <= sql4_nxt;
      sqh4_r   <= sqh4_nxt;
      lo4_r    <= lo4_nxt;
      vlo4_r   <= vlo4_nxt;
      tt4_r    <= tt4_nxt;
      off4_r   <= off3_r;
      sens4_r  <= sens3_r;
      rp4_r    <= rp3_r;
      off25_r  <= off25_nxt;
      sens25_r <= sens25_nxt;
      tm5_r    <= tm5_nxt;
      tneg5_r  <= tneg5_nxt;
      off5_r   <= off4_r;
      sens5_r  <= sens4_r;
      rp5_r    <= rp4_r;
      off6_r   <= off6_nxt;
      sens6_r  <= sens6_nxt;
      ten6_r   <= ten6_nxt;
      rp6_r    <= rp5_r;
    end
  end

  assign comp.valid  = v_r[5];
  assign comp.raw_p  = rp6_r;
  assign comp.tenths = ten6_r;
  assign comp.off    = off6_r;
  assign comp.sens   = sens6_r;

  // an accepted item enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    en && in_valid |=> v_r[0])
    else $error("accepted item did not enter stage one");

  // very low temperature lies inside the low region
  a_region: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] && vlo4_r |-> lo4_r)
    else $error("very low flag without low flag");

endmodule

// ----- rtl/bsc_press_calc.sv -----
// pressure pipeline: split product, scaling and saturation (four stages)
module bsc_press_calc import bsc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  bsc_comp_t comp,
  output logic      out_valid,
  output bsc_out_t  out_data
);

  logic [2:0] v_r, v_nxt;
  logic       ov_r;

  // stage 1: partial products of raw pressure and sensitivity
  logic [43:0]             pplo1_r, pplo1_nxt;
  logic signed [44:0]      pphi1_r, pphi1_nxt;
  logic signed [OS_W-1:0]  off1_r;
  logic signed [TEN_W-1:0] ten1_r;

  // stage 2: full product
  logic signed [63:0]      full2_r, full2_nxt;
  logic signed [OS_W-1:0]  off2_r;
  logic signed [TEN_W-1:0] ten2_r;

  // stage 3: scaled product less offset
  logic signed [63:0]      q1;
  logic signed [43:0]      x3_r, x3_nxt;
  logic signed [TEN_W-1:0] ten3_r;

  // stage 4: final scaling and saturation
  logic signed [43:0]      pq;
  bsc_out_t                od_r, od_nxt;

  assign v_nxt = {v_r[1:0], comp.valid};

  always_comb begin
    pplo1_nxt = comp.raw_p * comp.sens[19:0];
    pphi1_nxt = $signed({1'b0, comp.raw_p}) * $signed(comp.sens[39:20]);
  end

  always_comb begin
    full2_nxt = ($signed({{19{pphi1_r[44]}}, pphi1_r}) <<< 20)
              + $signed({20'h00000, pplo1_r});
  end

  // divisions truncate toward zero
  always_comb begin
    q1     = (full2_r + (full2_r[63] ? 64'sd2097151 : 64'sd0)) >>> 21;
    x3_nxt = $signed(q1[43:0]) - $signed({{4{off2_r[OS_W-1]}}, off2_r});
  end

  always_comb begin
    pq = (x3_r + (x3_r[43] ? 44'sd32767 : 44'sd0)) >>> 15;
    od_nxt.temperature_tenths = ten3_r;
    if (pq[43]) begin
      od_nxt.pressure_pascal  = '0;
      od_nxt.pressure_clamped = 1'b1;
    end else if (pq[42:PA_W] != '0) begin
      od_nxt.pressure_pascal  = PA_MAX;
      od_nxt.pressure_clamped = 1'b1;
    end else begin
      od_nxt.pressure_pascal  = pq[PA_W-1:0];
      od_nxt.pressure_clamped = 1'b0;
    end
  end

  // valid bits and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      ov_r <= 1'b0;
    end else if (en) begin
      v_r  <= v_nxt;
      ov_r <= v_r[2];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      pplo1_r <= pplo1_nxt;
      pphi1_r <= pphi1_nxt;
      off1_r  <= comp.off;
      ten1_r  <= comp.tenths;
      full2_r <= full2_nxt;
      off2_r  <= off1_r;
      ten2_r  <= ten1_r;
      x3_r    <= x3_nxt;
      ten3_r  <= ten2_r;
      od_r    <= od_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  // a clamped pressure sits at one of the two limits
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && od_r.pressure_clamped |->
      od_r.pressure_pascal == '0 || od_r.pressure_pascal == PA_MAX)
    else $error("clamped pressure not at a limit");

endmodule

// ----- rtl/baro_sensor_compensation_core.sv -----
// top level of the barometric sensor compensation core
// Takes one raw pressure and temperature conversion pair per item and returns
// the second-order compensated temperature in tenths of a degree and the
// pressure in pascal, saturated to 0..262143 with a flag. The datapath is a
// ten-stage pipeline (six stages for temperature, offset and sensitivity,
// four for the split pressure product and scaling) that takes one item every
// cycle unless stalled. The whole pipeline advances together and holds while
// a result waits on out_ready.
// Calibration words are written through cfg_we/cfg_index/cfg_wdata with the
// pipeline empty; writes to indexes above five are ignored.
module baro_sensor_compensation_core import bsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bsc_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bsc_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAL_W-1:0]     cfg_wdata
);

  bsc_cal_t  cal;
  bsc_comp_t comp;
  logic      en;

  // pipeline advances unless a finished item is stalled
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  bsc_cal_regs u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cal       (cal)
  );

  bsc_temp_comp u_temp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cal      (cal),
    .comp     (comp)
  );

  bsc_press_calc u_press (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .comp      (comp),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // temperature always stays within its physical bounds
  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_data.temperature_tenths) >= -16'sd26100 &&
                  $signed(out_data.temperature_tenths) <= 16'sd13400)
    else $error("temperature out of range");

endmodule
